### hdl/i2a_pkg.sv
// Package: types, constants and helpers for the integer to ASCII radix core.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int VALUE_W    = 32;
    localparam int DEC_DIGITS = (VALUE_W * 1233) / 4096 + 1;
    localparam int HEX_DIGITS = (VALUE_W + 3) / 4;
    localparam int BUF_W      = 4 * DEC_DIGITS;
    localparam int HEX_SHIFT  = BUF_W - 4 * HEX_DIGITS;
    localparam int BIN_SHIFT  = BUF_W - VALUE_W;
    localparam int CNT_W      = $clog2(VALUE_W + 1);

    localparam logic [1:0] OP_DEC = 2'd0;
    localparam logic [1:0] OP_HEX = 2'd1;
    localparam logic [1:0] OP_BIN = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_A    = 8'd97;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         op;
    } in_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } conv_status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'd0, d};
        end else begin
            c = ASCII_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

### hdl/integer_to_ascii_radix_core.sv
// Top level: unsigned integer to ASCII digits in decimal, hex or binary.
//
// Input channel s_*: one transfer carries a value and a radix code
// (0 decimal, 1 lower-case hex, 2 binary; code 3 is taken and produces nothing).
// Result channel m_*: one ASCII digit per transfer, most significant first,
// leading zeros dropped, last set on the final digit; zero gives a single '0'.
// Steps per item, from the input transfer to the load of the final digit into
// the output register:
//   decimal: the shift-add-3 steps in the BCD converter and a load, then the
//            leading zeros are dropped one by one (up to 9), the first digit is
//            reached and the digits are loaded one by one.
//   hex:     leading zeros dropped one by one (up to 7), the first digit reached
//            and the digits loaded one by one.
//   binary:  the same over 32 bit positions.
// s_ready is high only while idle, from the cycle after the final digit is loaded,
// so an item is taken only once the previous one is through; code 3 goes straight
// back to idle. The final digit may still wait in the output register. A stalled
// receiver holds m_data and pauses the digit scan. Reset (aresetn low, synchronous)
// empties the output register and returns the block to idle.
`timescale 1ns / 1ps

module integer_to_ascii_radix_core
    import i2a_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    state_t           state_reg, state_next;
    logic [BUF_W-1:0] dig_reg, dig_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       op_reg, op_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    logic             conv_start;
    conv_status_t     conv_status;
    logic [BUF_W-1:0] conv_bcd;

    logic             s_xfer;
    logic             out_load;
    logic [3:0]       top_digit;
    logic [BUF_W-1:0] dig_shifted;
    logic             last_digit;

    i2a_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (s_data.value),
        .status  (conv_status),
        .bcd     (conv_bcd)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_xfer     = s_valid && s_ready;
    assign out_load   = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign last_digit = (cnt_reg == CNT_W'(1));
    assign conv_start = s_xfer && (s_data.op == OP_DEC);

    always_comb begin
        if (op_reg == OP_BIN) begin
            top_digit   = {3'd0, dig_reg[BUF_W-1]};
            dig_shifted = {dig_reg[BUF_W-2:0], 1'b0};
        end else begin
            top_digit   = dig_reg[BUF_W-1 -: 4];
            dig_shifted = {dig_reg[BUF_W-5:0], 4'd0};
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (s_data.op)
                        OP_DEC:  state_next = ST_CONV;
                        OP_HEX:  state_next = ST_SKIP;
                        OP_BIN:  state_next = ST_SKIP;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (conv_status.done) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit != 4'd0 || last_digit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && last_digit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    op_next = s_data.op;
                    if (s_data.op == OP_HEX) begin
                        dig_next = BUF_W'(s_data.value) << HEX_SHIFT;
                        cnt_next = CNT_W'(HEX_DIGITS);
                    end else begin
                        dig_next = BUF_W'(s_data.value) << BIN_SHIFT;
                        cnt_next = CNT_W'(VALUE_W);
                    end
                end
            end
            ST_CONV: begin
                if (conv_status.done) begin
                    dig_next = conv_bcd;
                    cnt_next = CNT_W'(DEC_DIGITS);
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && !last_digit) begin
                    dig_next = dig_shifted;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next           = 1'b1;
                    m_data_next.ascii_char = digit_char(top_digit);
                    m_data_next.last       = last_digit;
                    dig_next               = dig_shifted;
                    cnt_next               = cnt_reg - CNT_W'(1);
                end
            end
            default: begin
                dig_next = dig_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
        dig_reg    <= dig_next;
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/i2a_dabble.sv
// Iterative binary to BCD converter, one shift-add-3 step per cycle.
`timescale 1ns / 1ps

module i2a_dabble
    import i2a_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] value,
    output conv_status_t       status,
    output logic [BUF_W-1:0]   bcd
);

    logic [VALUE_W-1:0] val_reg, val_next;
    logic [BUF_W-1:0]   bcd_reg, bcd_next;
    logic [BUF_W-1:0]   adj;
    logic [CNT_W-1:0]   iter_reg, iter_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        val_next  = val_reg;
        bcd_next  = bcd_reg;
        iter_next = iter_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            val_next  = value;
            bcd_next  = '0;
            iter_next = CNT_W'(VALUE_W);
            run_next  = 1'b1;
        end else if (run_reg) begin
            val_next  = {val_reg[VALUE_W-2:0], 1'b0};
            bcd_next  = {adj[BUF_W-2:0], val_reg[VALUE_W-1]};
            iter_next = iter_reg - CNT_W'(1);
            if (iter_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        val_reg <= val_next;
        bcd_reg <= bcd_next;
    end

    assign status.busy = run_reg;
    assign status.done = done_reg;
    assign bcd         = bcd_reg;

endmodule
